/* hdl/degree_quartile_edge_weighting_assert.svh */
// Assertion macros for the degree quartile edge weighting block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DEGREE_QUARTILE_EDGE_WEIGHTING_ASSERT_SVH
`define DEGREE_QUARTILE_EDGE_WEIGHTING_ASSERT_SVH

// same-cycle implication
`define DQEW_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dqew check failed");

// next-cycle implication
`define DQEW_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dqew check failed");

`endif

/* hdl/dqew_pkg.sv */
// Shared constants, types and helper functions of the degree quartile edge weighting block.
// No dependencies.
`timescale 1ns / 1ps

package dqew_pkg;

	localparam int MAX_NODES = 1024;
	localparam int IDX_W     = $clog2(MAX_NODES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int DEG_W     = 16;
	localparam int BIT_W     = $clog2(DEG_W);
	localparam int ID_W      = 32;
	localparam int CFG_W     = 11;
	localparam int OUT_IDX_W = 10;

	localparam logic [1:0] REQ_LOAD     = 2'd0;
	localparam logic [1:0] REQ_FINISH   = 2'd1;
	localparam logic [1:0] REQ_CLASSIFY = 2'd2;

	localparam logic [1:0] ST_EDGE    = 2'd0;
	localparam logic [1:0] ST_THR     = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic [3:0] PROB_TOP  = 4'd8;
	localparam logic [3:0] PROB_HIGH = 4'd4;
	localparam logic [3:0] PROB_MID  = 4'd2;
	localparam logic [3:0] PROB_LOW  = 4'd1;

	typedef struct packed {
		logic       take;
		logic       sweep_clr;
		logic       run_search;
		logic       run_sel;
		logic       run_clear;
		logic       put_u;
		logic       put_v;
		logic       deg_rd_u;
		logic       deg_rd_v;
		logic       deg_wr_u;
		logic       deg_wr_v;
		logic       latch_deg_u;
		logic       latch_deg_v;
		logic       sel_step;
		logic       res_load;
		logic [1:0] res_code;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic table_full;
		logic sel_last;
	} stat_t;

	function automatic logic [1:0] grade(input logic [DEG_W-1:0] d,
		input logic [DEG_W-1:0] lo, input logic [DEG_W-1:0] mid,
		input logic [DEG_W-1:0] hi);
		logic [1:0] g;
		if (d > hi) begin
			g = 2'd3;
		end else if (d > mid) begin
			g = 2'd2;
		end else if (d > lo) begin
			g = 2'd1;
		end else begin
			g = 2'd0;
		end
		return g;
	endfunction

	function automatic logic [3:0] prob_of(input logic [1:0] g);
		logic [3:0] p;
		unique case (g)
			2'd3: p = PROB_TOP;
			2'd2: p = PROB_HIGH;
			2'd1: p = PROB_MID;
			default: p = PROB_LOW;
		endcase
		return p;
	endfunction

endpackage

/* hdl/dqew_if.sv */
// Valid/ready channel interfaces for request items and result items.
// Depends on dqew_pkg for field widths.
`timescale 1ns / 1ps

interface dqew_in_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [dqew_pkg::ID_W-1:0] node_u;
	logic [dqew_pkg::ID_W-1:0] node_v;

	modport source (output valid, output req_type, output node_u, output node_v,
		input ready);
	modport sink (input valid, input req_type, input node_u, input node_v,
		output ready);
endinterface

interface dqew_out_if;
	logic                           valid;
	logic                           ready;
	logic [dqew_pkg::OUT_IDX_W-1:0] index_u;
	logic [dqew_pkg::OUT_IDX_W-1:0] index_v;
	logic [3:0]                     prob_tenths;
	logic [1:0]                     status;

	modport source (output valid, output index_u, output index_v,
		output prob_tenths, output status, input ready);
	modport sink (input valid, input index_u, input index_v,
		input prob_tenths, input status, output ready);
endinterface

/* hdl/dqew_datapath.sv */
// Datapath: id table, degree store, sweep counter, quartile selection and result register.
// Depends on dqew_pkg; driven by dqew_ctrl through cmd_t.
`timescale 1ns / 1ps

module dqew_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [dqew_pkg::CFG_W-1:0]      wr_data,
	input  logic [dqew_pkg::ID_W-1:0]       node_u,
	input  logic [dqew_pkg::ID_W-1:0]       node_v,
	input  dqew_pkg::cmd_t                  cmd,
	output dqew_pkg::stat_t                 stat,
	output logic [dqew_pkg::OUT_IDX_W-1:0]  index_u,
	output logic [dqew_pkg::OUT_IDX_W-1:0]  index_v,
	output logic [3:0]                      prob_tenths,
	output logic [1:0]                      status
);

	localparam logic [dqew_pkg::CNT_W-1:0] MAX_CNT = dqew_pkg::CNT_W'(dqew_pkg::MAX_NODES);
	localparam logic [dqew_pkg::DEG_W-1:0] DEG_MAX = '1;

	logic [dqew_pkg::CFG_W-1:0] node_count_q;
	logic [dqew_pkg::CNT_W-1:0] n_slots;
	logic [dqew_pkg::CNT_W-1:0] next_index_q;
	logic [dqew_pkg::CNT_W-1:0] cnt_q;
	logic [dqew_pkg::CNT_W-1:0] limit;
	logic                       valid_s1;
	logic [dqew_pkg::IDX_W-1:0] idx_s1;

	logic [dqew_pkg::ID_W-1:0]  u_q, v_q;
	logic                       fu_q, fv_q;
	logic [dqew_pkg::IDX_W-1:0] iu_q, iv_q;
	logic                       same;

	logic [dqew_pkg::ID_W-1:0]  id_mem [dqew_pkg::MAX_NODES];
	logic [dqew_pkg::ID_W-1:0]  id_rd_q;
	logic                       id_we;
	logic [dqew_pkg::ID_W-1:0]  id_wd;

	logic [dqew_pkg::DEG_W-1:0] deg_mem [dqew_pkg::MAX_NODES];
	logic [dqew_pkg::DEG_W-1:0] deg_rd_q;
	logic                       deg_we;
	logic [dqew_pkg::IDX_W-1:0] deg_wa, deg_ra;
	logic [dqew_pkg::DEG_W-1:0] deg_wd, deg_inc;

	logic [dqew_pkg::DEG_W-1:0] degu_q, degv_q;
	logic [dqew_pkg::DEG_W-1:0] thr_q [3];
	logic [dqew_pkg::DEG_W-1:0] t_q [3];
	logic [dqew_pkg::DEG_W-1:0] trial [3];
	logic [dqew_pkg::DEG_W-1:0] t_next [3];
	logic [dqew_pkg::CNT_W-1:0] c_q [3];
	logic [dqew_pkg::CNT_W-1:0] rank [3];
	logic [dqew_pkg::BIT_W-1:0] bit_q;
	logic [dqew_pkg::CNT_W+1:0] n3;

	logic [1:0]                 need;
	logic [dqew_pkg::CNT_W-1:0] room;
	logic [1:0]                 g_u, g_v, g_max;

	// effective slot count: zero counts as one, clamp to the store depth
	always_comb begin
		if (node_count_q == '0) begin
			n_slots = dqew_pkg::CNT_W'(1);
		end else if (dqew_pkg::CNT_W'(node_count_q) > MAX_CNT) begin
			n_slots = MAX_CNT;
		end else begin
			n_slots = dqew_pkg::CNT_W'(node_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= dqew_pkg::CFG_W'(1024);
		end else if (wr_en) begin
			node_count_q <= wr_data;
		end
	end

	// sweep counter shared by search, selection and the clearing pass
	always_comb begin
		if (cmd.run_search) begin
			limit = next_index_q;
		end else if (cmd.run_sel) begin
			limit = n_slots;
		end else begin
			limit = MAX_CNT;
		end
	end

	assign stat.sweep_done = (cnt_q >= limit) && !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.sweep_clr) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.run_search || cmd.run_sel || cmd.run_clear) begin
			valid_s1 <= cnt_q < limit;
			if (cnt_q < limit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[dqew_pkg::IDX_W-1:0];
	end

	// request operands and endpoint lookup
	assign same = (u_q == v_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			u_q <= node_u;
			v_q <= node_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fu_q <= 1'b0;
			fv_q <= 1'b0;
			iu_q <= '0;
			iv_q <= '0;
		end else if (cmd.take) begin
			fu_q <= 1'b0;
			fv_q <= 1'b0;
			iu_q <= '0;
			iv_q <= '0;
		end else if (cmd.run_search && valid_s1) begin
			if (id_rd_q == u_q) begin
				fu_q <= 1'b1;
				iu_q <= idx_s1;
			end
			if (id_rd_q == v_q) begin
				fv_q <= 1'b1;
				iv_q <= idx_s1;
			end
		end else if (cmd.put_u) begin
			if (!fu_q) begin
				fu_q <= 1'b1;
				iu_q <= next_index_q[dqew_pkg::IDX_W-1:0];
			end
		end else if (cmd.put_v) begin
			if (same) begin
				iv_q <= iu_q;
			end else if (!fv_q) begin
				fv_q <= 1'b1;
				iv_q <= next_index_q[dqew_pkg::IDX_W-1:0];
			end
		end
	end

	assign need = {1'b0, !fu_q} + {1'b0, !(fv_q || same)};
	assign room = (next_index_q < n_slots) ? (n_slots - next_index_q) : '0;
	assign stat.table_full = dqew_pkg::CNT_W'(need) > room;

	always_comb begin
		id_we = 1'b0;
		id_wd = u_q;
		if (cmd.put_u && !fu_q) begin
			id_we = 1'b1;
		end else if (cmd.put_v && !same && !fv_q) begin
			id_we = 1'b1;
			id_wd = v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_index_q <= '0;
		end else if (id_we) begin
			next_index_q <= next_index_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (id_we) begin
			id_mem[next_index_q[dqew_pkg::IDX_W-1:0]] <= id_wd;
		end
		id_rd_q <= id_mem[cnt_q[dqew_pkg::IDX_W-1:0]];
	end

	// degree store: clear sweep, saturating increments, reads
	assign deg_inc = (deg_rd_q == DEG_MAX) ? deg_rd_q : deg_rd_q + 1'b1;

	always_comb begin
		deg_we = 1'b0;
		deg_wa = cnt_q[dqew_pkg::IDX_W-1:0];
		deg_wd = '0;
		if (cmd.run_clear && cnt_q < MAX_CNT) begin
			deg_we = 1'b1;
		end else if (cmd.deg_wr_u) begin
			deg_we = 1'b1;
			deg_wa = iu_q;
			deg_wd = deg_inc;
		end else if (cmd.deg_wr_v) begin
			deg_we = 1'b1;
			deg_wa = iv_q;
			deg_wd = deg_inc;
		end
	end

	always_comb begin
		if (cmd.deg_rd_u) begin
			deg_ra = iu_q;
		end else if (cmd.deg_rd_v) begin
			deg_ra = iv_q;
		end else begin
			deg_ra = cnt_q[dqew_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		deg_rd_q <= deg_mem[deg_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_deg_u) begin
			degu_q <= deg_rd_q;
		end
		if (cmd.latch_deg_v) begin
			degv_q <= deg_rd_q;
		end
	end

	// quartile selection: one bit of all three thresholds per sweep, MSB first
	assign n3 = {n_slots, 1'b0} + {1'b0, n_slots};
	assign rank[0] = n_slots >> 2;
	assign rank[1] = n_slots >> 1;
	assign rank[2] = n3[dqew_pkg::CNT_W+1:2];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			trial[k]  = t_q[k] | (dqew_pkg::DEG_W'(1) << bit_q);
			t_next[k] = (c_q[k] <= rank[k]) ? trial[k] : t_q[k];
		end
	end

	assign stat.sel_last = (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			for (int k = 0; k < 3; k++) begin
				t_q[k]   <= '0;
				c_q[k]   <= '0;
				thr_q[k] <= '0;
			end
		end else begin
			if (cmd.take) begin
				bit_q <= dqew_pkg::BIT_W'(dqew_pkg::DEG_W - 1);
			end else if (cmd.sel_step) begin
				bit_q <= bit_q - 1'b1;
			end
			for (int k = 0; k < 3; k++) begin
				if (cmd.take) begin
					t_q[k] <= '0;
				end else if (cmd.sel_step) begin
					t_q[k] <= t_next[k];
					if (stat.sel_last) begin
						thr_q[k] <= t_next[k];
					end
				end
				if (cmd.sweep_clr) begin
					c_q[k] <= '0;
				end else if (cmd.run_sel && valid_s1 && deg_rd_q < trial[k]) begin
					c_q[k] <= c_q[k] + 1'b1;
				end
			end
		end
	end

	// classification and result register
	assign g_u   = dqew_pkg::grade(degu_q, thr_q[0], thr_q[1], thr_q[2]);
	assign g_v   = dqew_pkg::grade(degv_q, thr_q[0], thr_q[1], thr_q[2]);
	assign g_max = (g_v > g_u) ? g_v : g_u;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			if (cmd.res_code == dqew_pkg::ST_EDGE) begin
				index_u <= dqew_pkg::OUT_IDX_W'(iu_q);
				index_v <= dqew_pkg::OUT_IDX_W'(iv_q);
				if (fu_q && fv_q) begin
					prob_tenths <= dqew_pkg::prob_of(g_max);
					status      <= dqew_pkg::ST_EDGE;
				end else begin
					prob_tenths <= '0;
					status      <= dqew_pkg::ST_UNKNOWN;
				end
			end else begin
				index_u     <= '0;
				index_v     <= '0;
				prob_tenths <= '0;
				status      <= cmd.res_code;
			end
		end
	end

endmodule

/* hdl/dqew_ctrl.sv */
// Controller state machine: sequences search, placement, degree updates and selection.
// Depends on dqew_pkg; commands dqew_datapath through cmd_t.
`timescale 1ns / 1ps

module dqew_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      req_type,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  dqew_pkg::stat_t stat,
	output dqew_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SEARCH   = 4'd2;
	localparam logic [3:0] S_PLACE    = 4'd3;
	localparam logic [3:0] S_PUT_U    = 4'd4;
	localparam logic [3:0] S_PUT_V    = 4'd5;
	localparam logic [3:0] S_RD_U     = 4'd6;
	localparam logic [3:0] S_WR_U     = 4'd7;
	localparam logic [3:0] S_RD_V     = 4'd8;
	localparam logic [3:0] S_WR_V     = 4'd9;
	localparam logic [3:0] S_CRD_U    = 4'd10;
	localparam logic [3:0] S_CRD_V    = 4'd11;
	localparam logic [3:0] S_CLATCH   = 4'd12;
	localparam logic [3:0] S_SEL      = 4'd13;
	localparam logic [3:0] S_SEL_STEP = 4'd14;
	localparam logic [3:0] S_EMIT     = 4'd15;

	logic [3:0] state_q, state_d;
	logic [1:0] req_q;
	logic [1:0] kind_q, kind_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.res_code = kind_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.run_clear = 1'b1;
				if (stat.sweep_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.take      = 1'b1;
					cmd.sweep_clr = 1'b1;
					priority if (req_type == dqew_pkg::REQ_FINISH) begin
						state_d = S_SEL;
					end else if (req_type == dqew_pkg::REQ_LOAD ||
						req_type == dqew_pkg::REQ_CLASSIFY) begin
						state_d = S_SEARCH;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_SEARCH: begin
				cmd.run_search = 1'b1;
				if (stat.sweep_done) begin
					state_d = (req_q == dqew_pkg::REQ_LOAD) ? S_PLACE : S_CRD_U;
				end
			end
			S_PLACE: begin
				if (stat.table_full) begin
					kind_d  = dqew_pkg::ST_FULL;
					state_d = S_EMIT;
				end else begin
					state_d = S_PUT_U;
				end
			end
			S_PUT_U: begin
				cmd.put_u = 1'b1;
				state_d   = S_PUT_V;
			end
			S_PUT_V: begin
				cmd.put_v = 1'b1;
				state_d   = S_RD_U;
			end
			S_RD_U: begin
				cmd.deg_rd_u = 1'b1;
				state_d      = S_WR_U;
			end
			S_WR_U: begin
				cmd.deg_wr_u = 1'b1;
				state_d      = S_RD_V;
			end
			S_RD_V: begin
				cmd.deg_rd_v = 1'b1;
				state_d      = S_WR_V;
			end
			S_WR_V: begin
				cmd.deg_wr_v = 1'b1;
				state_d      = S_IDLE;
			end
			S_CRD_U: begin
				cmd.deg_rd_u = 1'b1;
				state_d      = S_CRD_V;
			end
			S_CRD_V: begin
				cmd.deg_rd_v    = 1'b1;
				cmd.latch_deg_u = 1'b1;
				state_d         = S_CLATCH;
			end
			S_CLATCH: begin
				cmd.latch_deg_v = 1'b1;
				kind_d          = dqew_pkg::ST_EDGE;
				state_d         = S_EMIT;
			end
			S_SEL: begin
				cmd.run_sel = 1'b1;
				if (stat.sweep_done) begin
					state_d = S_SEL_STEP;
				end
			end
			S_SEL_STEP: begin
				cmd.sel_step  = 1'b1;
				cmd.sweep_clr = 1'b1;
				if (stat.sel_last) begin
					kind_d  = dqew_pkg::ST_THR;
					state_d = S_EMIT;
				end else begin
					state_d = S_SEL;
				end
			end
			S_EMIT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			req_q       <= dqew_pkg::REQ_LOAD;
			kind_q      <= dqew_pkg::ST_EDGE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (accept) begin
				req_q <= req_type;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/degree_quartile_edge_weighting.sv */
// Channel   | dir | handshake       | payload
// item      | in  | valid / ready   | req_type, node_u, node_v
// result    | out | valid / ready   | index_u, index_v, prob_tenths, status
// wr_en     | in  | write enable    | wr_data (node_count)
//
// Reset runs a clearing pass over the degree store; no item is taken meanwhile.
// Load and classify each begin with an id search over the ids stored so far, and load
// ends early when the table is full; the id search reads one table entry per cycle.
// Finish runs one degree store sweep per bit.
// One item is in work at a time; a result waits in the output register while the next
// item is taken, and a stalled result holds the controller in its emit state.
`timescale 1ns / 1ps
`include "degree_quartile_edge_weighting_assert.svh"

module degree_quartile_edge_weighting (
	input  logic                       clk,
	input  logic                       arst_n,
	dqew_in_if.sink                    item,
	dqew_out_if.source                 result,
	input  logic                       wr_en,
	input  logic [dqew_pkg::CFG_W-1:0] wr_data
);

	dqew_pkg::cmd_t  cmd;
	dqew_pkg::stat_t stat;
	logic            item_take;
	logic            req_known;
	logic            prob_legal;

	dqew_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.req_type  (item.req_type),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dqew_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_data     (wr_data),
		.node_u      (item.node_u),
		.node_v      (item.node_v),
		.cmd         (cmd),
		.stat        (stat),
		.index_u     (result.index_u),
		.index_v     (result.index_v),
		.prob_tenths (result.prob_tenths),
		.status      (result.status)
	);

	assign item_take  = item.valid && item.ready;
	assign req_known  = (item.req_type == dqew_pkg::REQ_LOAD) ||
		(item.req_type == dqew_pkg::REQ_FINISH) || (item.req_type == dqew_pkg::REQ_CLASSIFY);
	assign prob_legal = (result.prob_tenths == dqew_pkg::PROB_TOP) ||
		(result.prob_tenths == dqew_pkg::PROB_HIGH) ||
		(result.prob_tenths == dqew_pkg::PROB_MID) ||
		(result.prob_tenths == dqew_pkg::PROB_LOW);

	`DQEW_ASSERT_NEXT(a_busy_after_take, item_take && req_known, !item.ready)
	`DQEW_ASSERT_NOW(a_prob_legal, result.valid && result.status == dqew_pkg::ST_EDGE, prob_legal)
	`DQEW_ASSERT_NOW(a_prob_zero, result.valid && result.status != dqew_pkg::ST_EDGE, result.prob_tenths == '0)

endmodule
